### sv/glcm_pkg.sv
// ----------------------------------------------------------------------------
// GLCM package
// Shared constants for the co-occurrence accumulator.
// ----------------------------------------------------------------------------
package glcm_pkg;
   localparam int CNT_W   = 23;
   localparam int LVL_W   = 4;
   localparam int MODE_W  = 2;
   localparam int DIR_W   = 2;
   localparam int CFG_IDX_W = 2;
   localparam int CFG_DAT_W = 13;

   localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [DIR_W-1:0] DIR_0   = 2'd0;
   localparam logic [DIR_W-1:0] DIR_45  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_90  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

   localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
endpackage

### sv/glcm_if.sv
// ----------------------------------------------------------------------------
// GLCM channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface glcm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [3:0] pixel_level;
   logic [1:0] direction;
   logic [3:0] row_level;
   logic [3:0] col_level;
   modport source (output valid, mode, pixel_level, direction, row_level, col_level,
                   input ready);
   modport sink   (input valid, mode, pixel_level, direction, row_level, col_level,
                   output ready);
endinterface

interface glcm_rsp_if;
   logic        valid;
   logic        ready;
   logic [22:0] pair_count;
   logic [22:0] denominator;
   logic        frame_done;
   modport source (output valid, pair_count, denominator, frame_done, input ready);
   modport sink   (input valid, pair_count, denominator, frame_done, output ready);
endinterface

interface glcm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [12:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/glcm_cooccurrence_accumulator.sv
// ----------------------------------------------------------------------------
// GLCM co-occurrence accumulator, four directions, symmetric
// Counts level pairs of a raster-order frame in one count memory.
// ----------------------------------------------------------------------------
// A read request passes through S_WAIT, which loads the count into the response.
// A pixel keeps the block busy through S_FETCH and S_PLAN, then S_RD, S_WAIT and
//   S_WR for each of P store increments (up to 8), before the next request is taken.
// After reset or a clear request, a clearing pass sweeps both memories, one entry
//   per cycle, during which no request is accepted. Registers reset to 1024/1024/16.
module glcm_cooccurrence_accumulator
   import glcm_pkg::*;
#(
   parameter int MAX_LEVELS = 16,
   parameter int MAX_WIDTH  = 1024
) (
   input  logic clock,
   input  logic reset,
   glcm_req_if.sink   req,
   glcm_rsp_if.source rsp,
   glcm_csr_if.sink   csr
);
   localparam int MAX_HEIGHT = 4096;
   localparam int LW   = $clog2(MAX_LEVELS);
   localparam int SD   = 4 * MAX_LEVELS * MAX_LEVELS;
   localparam int SA   = $clog2(SD);
   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = 12;
   localparam int CLRN = (SD > MAX_WIDTH) ? SD : MAX_WIDTH;
   localparam int CW   = $clog2(CLRN) + 1;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_FETCH = 7'b0000100,
      S_PLAN  = 7'b0001000,
      S_RD    = 7'b0010000,
      S_WAIT  = 7'b0100000,
      S_WR    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // register file
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [4:0]  levels_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 13'd1024;
         levels_ff <= 5'd16;
      end else if (csr.valid) begin
         case (csr.index)
            REG_WIDTH:  width_ff  <= csr.data[10:0];
            REG_HEIGHT: height_ff <= csr.data;
            REG_LEVELS: levels_ff <= csr.data[4:0];
            default: ;
         endcase
      end
   end

   // effective (clamped) configuration
   logic [13:0] eff_w, eff_h;
   logic [8:0]  eff_l;
   always_comb begin
      eff_w = (width_ff < 11'd2) ? 14'd2 :
              ({3'd0, width_ff} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {3'd0, width_ff};
      eff_h = (height_ff < 13'd2) ? 14'd2 :
              ({1'b0, height_ff} > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : {1'b0, height_ff};
      eff_l = (levels_ff < 5'd2) ? 9'd2 :
              ({4'd0, levels_ff} > 9'(MAX_LEVELS)) ? 9'(MAX_LEVELS) : {4'd0, levels_ff};
   end

   function automatic logic [LW-1:0] sat(input logic [3:0] v, input logic [8:0] l);
      logic [8:0] top;
      top = l - 9'd1;
      return ({5'd0, v} > top) ? top[LW-1:0] : LW'(v);
   endfunction

   // denominators, computed at leisure from registers (one multiplier each)
   logic [22:0] den_ff [4];
   always_ff @(posedge clock) begin
      den_ff[0] <= 23'(2 * 32'(eff_h) * 32'(eff_w - 14'd1));
      den_ff[2] <= 23'(2 * 32'(eff_h - 14'd1) * 32'(eff_w));
      den_ff[1] <= 23'(2 * 32'(eff_h - 14'd1) * 32'(eff_w - 14'd1));
      den_ff[3] <= 23'(2 * 32'(eff_h - 14'd1) * 32'(eff_w - 14'd1));
   end

   // position and neighbor state
   logic [XW-1:0]  col_ff;
   logic [YW-1:0]  row_ff;
   logic [LW-1:0]  left_ff, upleft_ff, cur_ff;
   logic           full_ff;
   logic [CW-1:0]  clr_ff;
   logic [2:0]     op_ff;
   logic [3:0]     nops_ff;
   logic [SA-1:0]  ops_ff [8];
   logic [SA-1:0]  waddr_ff;
   logic [CNT_W-1:0] wdata_ff;
   logic           rdreq_ff;
   logic [DIR_W-1:0] rdir_ff;

   // memories
   logic             cs_we, pr_we;
   logic [SA-1:0]    cs_wa, cs_ra;
   logic [CNT_W-1:0] cs_wd, cs_rd;
   logic [XW-1:0]    pr_wa, pr_ra;
   logic [LW-1:0]    pr_wd, pr_rd;

   glcm_ram #(.WIDTH(CNT_W), .DEPTH(SD)) u_count (
      .clock, .wr_en(cs_we), .wr_addr(cs_wa), .wr_data(cs_wd),
      .rd_addr(cs_ra), .rd_data(cs_rd));
   glcm_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_prev (
      .clock, .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(pr_wd),
      .rd_addr(pr_ra), .rd_data(pr_rd));

   // a waiting response holds back only read requests; pixels and clears pass
   logic req_fire, rsp_busy;
   logic [LW-1:0] lvl_in, r_in, k_in;
   assign rsp_busy = rsp.valid & ~rsp.ready;
   assign req.ready = (state_ff == S_IDLE) & ~(rsp_busy & (req.mode == MODE_READ));
   assign req_fire  = req.valid & req.ready;
   assign lvl_in = sat(req.pixel_level, eff_l);
   assign r_in   = sat(req.row_level, eff_l);
   assign k_in   = sat(req.col_level, eff_l);

   function automatic logic [SA-1:0] addr(input logic [1:0] d, input logic [LW-1:0] a,
                                          input logic [LW-1:0] b);
      return {d, a, b};
   endfunction

   // next x within the row
   logic [XW:0] xn;
   logic        row_end, up_right_ok;
   assign xn = {1'b0, col_ff} + 1'b1;
   assign row_end = ({{(13-XW){1'b0}}, xn} >= eff_w);
   assign up_right_ok = !row_end && (xn < (XW+1)'(MAX_WIDTH));

   // pair list, built in S_PLAN (up available) with up-right arriving later
   logic [2:0] np;
   logic [SA-1:0] pl [8];
   always_comb begin
      np = 3'd0;
      for (int i = 0; i < 8; i++) pl[i] = '0;
      if (col_ff != '0) begin
         pl[np] = addr(DIR_0, cur_ff, left_ff); pl[np+1] = addr(DIR_0, left_ff, cur_ff);
         np = np + 3'd2;
      end
      if (row_ff != '0) begin
         pl[np] = addr(DIR_90, cur_ff, pr_rd); pl[np+1] = addr(DIR_90, pr_rd, cur_ff);
         np = np + 3'd2;
         if (col_ff != '0) begin
            pl[np] = addr(DIR_45, cur_ff, upleft_ff);
            pl[np+1] = addr(DIR_45, upleft_ff, cur_ff);
            np = np + 3'd2;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cs_we = 1'b0; cs_wa = waddr_ff; cs_wd = wdata_ff;
      cs_ra = ops_ff[op_ff];
      pr_we = 1'b0; pr_wa = col_ff; pr_wd = cur_ff;
      pr_ra = col_ff;
      case (state_ff)
         S_CLEAR: begin
            cs_we = (clr_ff < CW'(SD));
            cs_wa = clr_ff[SA-1:0]; cs_wd = '0;
            pr_we = (clr_ff < CW'(MAX_WIDTH));
            pr_wa = clr_ff[XW-1:0]; pr_wd = '0;
            if (clr_ff == CW'(CLRN - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            cs_ra = addr(req.direction, r_in, k_in);
            if (req_fire) begin
               case (req.mode)
                  MODE_PIXEL: if (!full_ff) state_in = S_FETCH;
                  MODE_READ:  state_in = S_WAIT;
                  MODE_CLEAR: state_in = S_CLEAR;
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            // read up (x) now; up-right read next
            pr_ra = col_ff;
            state_in = S_PLAN;
         end
         S_PLAN: begin
            // store the current level as the previous-row entry of column x
            pr_we = 1'b1;
            pr_ra = xn[XW-1:0];
            state_in = (np == 3'd0) ? S_IDLE : S_RD;
         end
         S_RD: state_in = S_WAIT;
         S_WAIT: state_in = rdreq_ff ? S_IDLE : S_WR;
         S_WR: begin
            cs_we = 1'b1;
            state_in = (({1'b0, op_ff} + 4'd1) == nops_ff) ? S_IDLE : S_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   logic urok_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         col_ff   <= '0; row_ff <= '0;
         left_ff  <= '0; upleft_ff <= '0;
         full_ff  <= 1'b0;
         op_ff    <= '0; nops_ff <= '0;
         rdreq_ff <= 1'b0;
         urok_ff  <= 1'b0;
         rsp.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         // load the response for a read, else drop it once taken
         if (state_ff == S_WAIT && rdreq_ff) begin
            rsp.valid <= 1'b1;
            rsp.pair_count <= cs_rd;
            rsp.denominator <= den_ff[rdir_ff];
            rsp.frame_done <= full_ff;
         end else if (rsp.valid && rsp.ready) begin
            rsp.valid <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: clr_ff <= clr_ff + 1'b1;
            S_IDLE: if (req_fire) begin
               clr_ff <= '0;
               op_ff <= '0; nops_ff <= '0;
               rdreq_ff <= (req.mode == MODE_READ);
               rdir_ff <= req.direction;
               if (req.mode == MODE_CLEAR) begin
                  col_ff <= '0; row_ff <= '0; left_ff <= '0; upleft_ff <= '0;
                  full_ff <= 1'b0;
               end
               cur_ff <= lvl_in;
            end
            S_FETCH: ;
            S_PLAN: begin
               // pr_rd holds up(x)
               for (int i = 0; i < 8; i++) ops_ff[i] <= pl[i];
               nops_ff <= {1'b0, np};
               urok_ff <= (row_ff != '0) && up_right_ok;
               op_ff <= '0;
               // advance position and neighbors
               upleft_ff <= pr_rd;
               left_ff   <= cur_ff;
               if (row_end) begin
                  col_ff <= '0;
                  if ({2'd0, row_ff} + 14'd1 >= eff_h) full_ff <= 1'b1;
                  else row_ff <= row_ff + 1'b1;
               end else begin
                  col_ff <= xn[XW-1:0];
               end
            end
            S_RD: begin
               if (urok_ff) begin
                  // up-right value arrived; append its two increments
                  ops_ff[nops_ff[2:0]]        <= addr(DIR_135, cur_ff, pr_rd);
                  ops_ff[nops_ff[2:0] + 3'd1] <= addr(DIR_135, pr_rd, cur_ff);
                  nops_ff <= nops_ff + 4'd2;
                  urok_ff <= 1'b0;
               end
               waddr_ff <= ops_ff[op_ff];
            end
            S_WAIT: if (!rdreq_ff) begin
               wdata_ff <= (cs_rd == CNT_MAX) ? cs_rd : cs_rd + 1'b1;
            end else begin
               rdreq_ff <= 1'b0;
            end
            S_WR: op_ff <= op_ff + 1'b1;
            default: ;
         endcase
      end
   end

   property p_no_req_in_clear;
      @(posedge clock) disable iff (reset) (state_ff == S_CLEAR) |-> !req.ready;
   endproperty
   a_no_req_in_clear: assert property (p_no_req_in_clear) else $error("accept in clear");

   property p_rsp_hold;
      @(posedge clock) disable iff (reset) rsp.valid && !rsp.ready |=> rsp.valid;
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("response dropped");

   property p_ops_bound;
      @(posedge clock) disable iff (reset) (state_ff == S_WR) |-> ({1'b0, op_ff} < nops_ff);
   endproperty
   a_ops_bound: assert property (p_ops_bound) else $error("increment index overrun");

   property p_full_no_pixel;
      @(posedge clock) disable iff (reset) full_ff && (state_ff == S_IDLE) |=>
         (state_ff != S_FETCH);
   endproperty
   a_full_no_pixel: assert property (p_full_no_pixel) else $error("pixel after frame full");
endmodule

### sv/glcm_ram.sv
// ----------------------------------------------------------------------------
// GLCM generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module glcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
